FILE: hw/rtl/odo_pkg.sv
// Shared types, constants and arithmetic helpers for the wheel odometry block.
`timescale 1ns / 1ps

package odo_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN  = 2'd1;

  localparam logic [31:0] DISTANCE_GAIN_RST = 32'd629233;
  localparam logic [23:0] HEADING_GAIN_RST  = 24'd136620;

  // CORDIC sizing.
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned ITER_W       = 5;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam int unsigned CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;

  // Width of the wide products and of the saturation input.
  localparam int unsigned WIDE_W = 66;

  typedef struct packed {
    logic signed [15:0] right_ticks;
    logic signed [15:0] left_ticks;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [23:0] yaw;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [23:0] step_yaw;
  } odo_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROT,
    ST_MULX,
    ST_RNDX,
    ST_RNDY,
    ST_ACC
  } odo_state_t;

  typedef struct packed {
    logic load_in;
    logic cfg_wr;
    logic prep;
    logic rot;
    logic mul_en;
    logic mul_sel_y;
    logic rnd_x;
    logic rnd_y;
    logic commit;
  } odo_cmd_t;

  // Arctangent of 2^-i in units of 2^-32 turn, as used by the rotation steps.
  function automatic logic [29:0] atan_turn(input logic [ITER_W-1:0] i);
    logic [29:0] r;
    case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41721;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2607;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      5'd24:   r = 30'd41;
      5'd25:   r = 30'd20;
      5'd26:   r = 30'd10;
      5'd27:   r = 30'd5;
      5'd28:   r = 30'd3;
      5'd29:   r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [31:0] r;
    if (v[WIDE_W-1:31] == {(WIDE_W-31){v[WIDE_W-1]}}) begin
      r = v[31:0];
    end else if (v[WIDE_W-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/odo_ctrl.sv
// Sequencing state machine of the wheel odometry block.
`timescale 1ns / 1ps

module odo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              rot_done,
  output odo_pkg::odo_cmd_t cmd
);

  odo_pkg::odo_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= odo_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      odo_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = odo_pkg::ST_PREP;
      end
      odo_pkg::ST_PREP: state_nxt = odo_pkg::ST_ROT;
      odo_pkg::ST_ROT: begin
        if (rot_done) state_nxt = odo_pkg::ST_MULX;
      end
      odo_pkg::ST_MULX: state_nxt = odo_pkg::ST_RNDX;
      odo_pkg::ST_RNDX: state_nxt = odo_pkg::ST_RNDY;
      odo_pkg::ST_RNDY: state_nxt = odo_pkg::ST_ACC;
      odo_pkg::ST_ACC: begin
        if (!out_valid_r || !out_stall) state_nxt = odo_pkg::ST_IDLE;
      end
      default: state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      odo_pkg::ST_IDLE: begin
        cmd.load_in = in_valid;
        cmd.cfg_wr  = cfg_valid;
      end
      odo_pkg::ST_PREP: cmd.prep = 1'b1;
      odo_pkg::ST_ROT:  cmd.rot  = 1'b1;
      odo_pkg::ST_MULX: cmd.mul_en = 1'b1;
      odo_pkg::ST_RNDX: begin
        cmd.rnd_x     = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_y = 1'b1;
      end
      odo_pkg::ST_RNDY: cmd.rnd_y = 1'b1;
      odo_pkg::ST_ACC:  cmd.commit = !out_valid_r || !out_stall;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != odo_pkg::ST_IDLE);
  assign cfg_ready = (state_r == odo_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/odo_datapath.sv
// Datapath of the wheel odometry block: gains, travel, CORDIC and accumulators.
`timescale 1ns / 1ps

module odo_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  odo_pkg::odo_cmd_t                   cmd,
  input  odo_pkg::odo_in_t                    in_data,
  input  logic [odo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                         cfg_data,
  output logic                                rot_done,
  output odo_pkg::odo_out_t                   out_data
);

  localparam int unsigned W  = odo_pkg::WIDE_W;
  localparam int unsigned CW = odo_pkg::CORDIC_W;

  // Configuration and odometry state.
  logic        [31:0] dg_r;
  logic        [23:0] hg_r;
  logic signed [31:0] x_acc_r;
  logic signed [31:0] y_acc_r;
  logic        [23:0] heading_r;
  logic [odo_pkg::ITER_W-1:0] iter_r;

  // Per-item working registers.
  odo_pkg::odo_in_t   in_r;
  logic signed [31:0] travel_r;
  logic        [23:0] dyaw_r;
  logic         [1:0] quad_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic signed [W-1:0]  prod_r;
  logic signed [31:0] dx_r, dy_r;
  odo_pkg::odo_out_t  out_r;

  logic signed [16:0] tick_sum, tick_diff;
  logic signed [49:0] dist_prod;
  logic signed [W-1:0] dist_rnd;
  logic        [23:0] diff24, dyaw_prod;
  logic        [24:0] quad_sum;
  logic         [1:0] quad;
  logic        [23:0] resid;
  logic signed [CW-1:0] z_init, x_sh, y_sh, atan_v;
  logic signed [CW-1:0] cos_v, sin_v, mul_opnd;
  logic signed [W-1:0]  mul_prod, rnd_v;
  logic signed [31:0] step_sat;
  logic signed [W-1:0]  x_sum, y_sum;
  logic signed [31:0] x_new, y_new;
  logic        [23:0] heading_new;

  // Travel and heading change.
  assign tick_sum  = {in_r.right_ticks[15], in_r.right_ticks}
                   + {in_r.left_ticks[15], in_r.left_ticks};
  assign tick_diff = {in_r.left_ticks[15], in_r.left_ticks}
                   - {in_r.right_ticks[15], in_r.right_ticks};
  assign dist_prod = $signed({{33{tick_sum[16]}}, tick_sum}) * $signed({18'd0, dg_r});
  assign dist_rnd  = ($signed({{(W-50){dist_prod[49]}}, dist_prod}) + 66'sd128) >>> 8;
  assign diff24    = {{7{tick_diff[16]}}, tick_diff};
  assign dyaw_prod = diff24 * hg_r;

  // Reduce the heading to the nearest quadrant and a residual angle.
  assign quad_sum = {1'b0, heading_r} + 25'h020_0000;
  assign quad     = quad_sum[23:22];
  assign resid    = heading_r - {quad, 22'd0};
  assign z_init   = $signed({{2{resid[23]}}, resid, 8'd0});

  // One rotation step.
  assign x_sh   = cx_r >>> iter_r;
  assign y_sh   = cy_r >>> iter_r;
  assign atan_v = $signed({4'd0, odo_pkg::atan_turn(iter_r)});
  assign rot_done = (iter_r == odo_pkg::ITER_LAST);

  // Map the rotated vector back to its quadrant.
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_v = cx_r;
        sin_v = cy_r;
      end
      2'd1: begin
        cos_v = -cy_r;
        sin_v = cx_r;
      end
      2'd2: begin
        cos_v = -cx_r;
        sin_v = -cy_r;
      end
      default: begin
        cos_v = cy_r;
        sin_v = -cx_r;
      end
    endcase
  end

  assign mul_opnd = cmd.mul_sel_y ? sin_v : cos_v;
  assign mul_prod = $signed({{(W-32){travel_r[31]}}, travel_r})
                  * $signed({{(W-CW){mul_opnd[CW-1]}}, mul_opnd});
  assign rnd_v    = (prod_r + 66'sd536870912) >>> 30;
  assign step_sat = odo_pkg::sat32(rnd_v);

  // Accumulator update.
  assign x_sum = $signed({{(W-32){x_acc_r[31]}}, x_acc_r})
               + $signed({{(W-32){dx_r[31]}}, dx_r});
  assign y_sum = $signed({{(W-32){y_acc_r[31]}}, y_acc_r})
               + $signed({{(W-32){dy_r[31]}}, dy_r});
  assign x_new       = odo_pkg::sat32(x_sum);
  assign y_new       = odo_pkg::sat32(y_sum);
  assign heading_new = heading_r + dyaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dg_r      <= odo_pkg::DISTANCE_GAIN_RST;
      hg_r      <= odo_pkg::HEADING_GAIN_RST;
      x_acc_r   <= '0;
      y_acc_r   <= '0;
      heading_r <= '0;
      iter_r    <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        unique case (cfg_index)
          odo_pkg::CFG_DISTANCE_GAIN: dg_r <= cfg_data;
          odo_pkg::CFG_HEADING_GAIN:  hg_r <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.prep) begin
        iter_r <= '0;
      end else if (cmd.rot) begin
        iter_r <= iter_r + 1'b1;
      end
      if (cmd.commit) begin
        x_acc_r   <= x_new;
        y_acc_r   <= y_new;
        heading_r <= heading_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.prep) begin
      travel_r <= odo_pkg::sat32(dist_rnd);
      dyaw_r   <= dyaw_prod;
      quad_r   <= quad;
      cx_r     <= odo_pkg::CORDIC_K;
      cy_r     <= '0;
      cz_r     <= z_init;
    end else if (cmd.rot) begin
      if (!cz_r[CW-1]) begin
        cx_r <= cx_r - y_sh;
        cy_r <= cy_r + x_sh;
        cz_r <= cz_r - atan_v;
      end else begin
        cx_r <= cx_r + y_sh;
        cy_r <= cy_r - x_sh;
        cz_r <= cz_r + atan_v;
      end
    end
    if (cmd.mul_en) begin
      prod_r <= mul_prod;
    end
    if (cmd.rnd_x) begin
      dx_r <= step_sat;
    end
    if (cmd.rnd_y) begin
      dy_r <= step_sat;
    end
    if (cmd.commit) begin
      out_r.pos_x    <= x_new;
      out_r.pos_y    <= y_new;
      out_r.yaw      <= heading_new;
      out_r.step_x   <= dx_r;
      out_r.step_y   <= dy_r;
      out_r.step_yaw <= dyaw_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hw/rtl/diff_drive_odometry.sv
// Top level of the differential-drive wheel odometry block.
`timescale 1ns / 1ps

// Dead-reckoning odometry for a two-wheeled robot. Each input transfer carries the signed
// right and left encoder tick changes since the previous one; each produces exactly one
// result transfer with the new Q16.16 position, the 24-bit binary heading and the step
// taken. Travel is distance_gain times the tick sum, spread onto x and y by the cosine and
// sine of the heading held before the item; the heading then moves by heading_gain times
// (left minus right) and wraps modulo one turn, while positions saturate at the signed
// 32-bit limits. An item occupies the block from its input transfer to the next possible
// one: a set-up step, the rotation steps of the single shift-and-add CORDIC unit that
// produces cosine and sine, steps in which one shared multiplier scales the travel onto
// x and then y with rounding, and a commit step that updates the state
// and loads the result register. The result register frees the input side: a new input
// transfer is taken while an earlier result still waits, and only the commit of the next
// item holds off until that result has been taken. Registers are written through the
// configuration port while no item is in progress; cfg_ready is high exactly when the
// block is idle, and writes to indexes beyond the two registers are ignored.

module diff_drive_odometry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  odo_pkg::odo_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output odo_pkg::odo_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [odo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  // Commands from the sequencer and the end-of-rotation status back to it.
  odo_pkg::odo_cmd_t cmd;
  logic              rot_done;

  // The controller owns the handshakes and the order of the datapath steps.
  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .rot_done  (rot_done),
    .cmd       (cmd)
  );

  // The datapath holds the gains, the position and heading, and the result register.
  odo_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rot_done  (rot_done),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/odo_checker.sv
// Port-level checks for the wheel odometry block, bound to its top level.
`timescale 1ns / 1ps

module odo_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input odo_pkg::odo_out_t out_data
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // After an input transfer the block is busy with that item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while the first is in progress");

  // The block is still busy while the rotation runs after the transfer.
  a_busy_through_rotation: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> ##30 in_stall)
    else $error("item finished before the rotation could complete");

  // A new result appears only as the block returns to idle.
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while an item is still in progress");

endmodule

bind diff_drive_odometry odo_checker u_odo_checker (.*);
